@@ sv/periodic_task_timer_table_unit_macros.svh @@
// Assertion macros for the periodic task timer table unit.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_UNIT_MACROS_SVH
// Assert a property on the rising clock, disabled during reset.
`define PTT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Assert that a condition never holds on the rising clock.
`define PTT_NEVER(label, prop) \
	`PTT_ASSERT(label, !(prop))
`endif

@@ sv/ptt_pkg.sv @@
// Package for the periodic task timer table: sizes, request codes, slot and cell command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;
	localparam int SLOTS = 10;
	localparam int IDX_W = 4;
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_CREATE = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_UNDEF  = 2'd3;
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] reload;
		logic [15:0] remaining;
		logic [15:0] repeats;
		logic [31:0] ctx;
		logic        fast;
	} slot_t;
	// Command broadcast along the chain of cells.
	typedef struct packed {
		logic        wr;
		logic        clr;
		logic        dec;
		logic        fire;
		logic [IDX_W-1:0] sel;
		slot_t       data;
	} cell_cmd_t;
endpackage
`default_nettype wire

@@ sv/periodic_task_timer_table_unit.sv @@
// Periodic task timer table: SLOTS slots held in a ring of cells that rotate
// one position per cycle past a head while a pass runs and no result stalls,
// where each slot is updated as it passes. Create and remove walk the ring
// once, then write or clear the slot and return the result in the done state.
// A tick walks the ring twice, fast firings in the first pass and slow ones in
// the second: one result per firing, the last marked, none if nothing fires.
// A result that waits untaken in the one-entry output register freezes the
// walk. Only one request is in work at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_timer_table_unit_macros.svh"
module periodic_task_timer_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: task_id[15:0], delay[31:16], repeat_count[47:32], context_req[79:48]
	input  wire logic [79:0] s_tdata,
	// tuser: req_type[1:0], in_isr[2]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: slot_index[3:0], fired_id[19:4], fired_context[51:20], zero fill
	output logic [55:0]      m_tdata,
	// tuser: fired[0], fired_in_isr[1], status[2]
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);
	import ptt_pkg::*;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_P1   = 2'd1;
	localparam logic [1:0] ST_P2   = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	logic [1:0] state_q;
	logic [IDX_W-1:0] cnt_q;   // ring position at head
	logic [79:0] req_q;
	logic [1:0] rq_q;
	logic isr_q;
	logic [IDX_W:0] hit_q;     // found slot (MSB = none)
	logic [IDX_W:0] free_q;
	slot_t ring [SLOTS];
	slot_t fwd [SLOTS];
	cell_cmd_t cmd;
	logic shift;
	logic stall;
	logic ov_q;
	logic [55:0] od_q;
	logic [2:0] ou_q;
	logic ol_q;
	logic pend_q;              // a fired result awaits its last flag
	logic [55:0] pd_q;
	logic [2:0] pu_q;
	logic [15:0] rid;
	slot_t h;
	logic emit;
	logic [55:0] ed;
	logic [2:0] eu;
	logic [IDX_W:0] tgt;
	logic wr_ok;
	logic [IDX_W-1:0] wr_idx;
	logic out_load;
	logic [55:0] out_d;
	logic [2:0] ou_d;
	logic ol_d;
	assign rid = req_q[15:0];
	assign h   = ring[0];
	// Ring of cells: cell i takes the updated slot of its neighbor.
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		ptt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift),
			.shin(fwd[(g + 1) % SLOTS]), .cmd(cmd), .here(cmd.sel == IDX_W'(g)),
			.slot(ring[g]), .fwd(fwd[g])
		);
	end
	// Output slot free unless a result is held and not taken.
	assign stall = ov_q && !m_tready;
	// Pick the slot a create or remove writes.
	always_comb begin
		tgt = (hit_q[IDX_W] == 1'b0) ? hit_q : free_q;
		if (rq_q == REQ_CREATE) begin
			wr_ok = !tgt[IDX_W];
			wr_idx = tgt[IDX_W-1:0];
		end else begin
			wr_ok = !hit_q[IDX_W];
			wr_idx = hit_q[IDX_W-1:0];
		end
	end
	// Head processing per pass and result selection.
	always_comb begin
		cmd = '0;
		cmd.data = h;
		shift = 1'b0;
		emit = 1'b0;
		ed = '0;
		eu = '0;
		out_load = 1'b0;
		out_d = pd_q;
		ou_d = pu_q;
		ol_d = 1'b0;
		if (state_q == ST_P1 && !stall) begin
			shift = 1'b1;
			if (rq_q == REQ_TICK && h.remaining != 16'd0) begin
				cmd.dec = 1'b1;
				if (h.remaining == 16'd1 && h.fast) begin
					cmd.fire = 1'b1;
					emit = 1'b1;
					eu = 3'b011;
					ed = {4'd0, h.ctx, h.id, cnt_q};
				end
			end
		end else if (state_q == ST_P2 && !stall) begin
			shift = 1'b1;
			if (!h.fast && h.remaining == 16'd0 && h.repeats != 16'd0) begin
				cmd.fire = 1'b1;
				emit = 1'b1;
				eu = 3'b001;
				ed = {4'd0, h.ctx, h.id, cnt_q};
			end
		end else if (state_q == ST_DONE && !stall) begin
			ol_d = 1'b1;
			if (rq_q == REQ_TICK) out_load = pend_q;
			else begin
				out_load = 1'b1;
				cmd.sel = wr_idx;
				cmd.wr  = (rq_q == REQ_CREATE) && wr_ok;
				cmd.clr = (rq_q == REQ_REMOVE) && wr_ok;
				out_d = '0;
				ou_d = {(rq_q == REQ_CREATE) && !wr_ok, 2'b00};
				if (wr_ok) out_d[IDX_W-1:0] = wr_idx;
			end
		end
		// Release the pending firing once a newer one shows it was not the last.
		if (emit && pend_q) out_load = 1'b1;
		if (cmd.wr) begin
			cmd.data.id = rid;
			cmd.data.reload = req_q[31:16];
			cmd.data.remaining = req_q[31:16];
			cmd.data.repeats = req_q[47:32];
			cmd.data.ctx = req_q[79:48];
			cmd.data.fast = isr_q;
		end
	end
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata = od_q;
	assign m_tuser = ou_q;
	assign m_tlast = ol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			req_q <= '0;
			rq_q <= '0;
			isr_q <= 1'b0;
			hit_q <= '1;
			free_q <= '1;
			ov_q <= 1'b0;
			od_q <= '0;
			ou_q <= '0;
			ol_q <= 1'b0;
			pend_q <= 1'b0;
			pd_q <= '0;
			pu_q <= '0;
		end else begin
			// Load the output register or drop a taken result.
			if (out_load) begin
				ov_q <= 1'b1;
				od_q <= out_d;
				ou_q <= ou_d;
				ol_q <= ol_d;
			end else if (m_tready) ov_q <= 1'b0;
			// Hold the newest firing until its last flag is known.
			if (emit) begin
				pend_q <= 1'b1;
				pd_q <= ed;
				pu_q <= eu;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q <= s_tdata;
						rq_q <= s_tuser[1:0];
						isr_q <= s_tuser[2];
						cnt_q <= '0;
						hit_q <= '1;
						free_q <= '1;
						pend_q <= 1'b0;
						state_q <= (s_tuser[1:0] == REQ_UNDEF) ? ST_IDLE : ST_P1;
					end
				end
				ST_P1, ST_P2: begin
					if (!stall) begin
						// search for create/remove during first pass
						if (state_q == ST_P1 && rq_q != REQ_TICK) begin
							if (rid != 16'd0 && h.id == rid && hit_q[IDX_W])
								hit_q <= {1'b0, cnt_q};
							if (h.repeats == 16'd0 && free_q[IDX_W])
								free_q <= {1'b0, cnt_q};
						end
						if (cnt_q == IDX_W'(SLOTS - 1)) begin
							cnt_q <= '0;
							state_q <= (state_q == ST_P1 && rq_q == REQ_TICK)
								? ST_P2 : ST_DONE;
						end else cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (!stall) begin
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	`PTT_NEVER(a_ready_busy, s_tready && state_q != ST_IDLE)
	`PTT_ASSERT(a_idx_range, !m_tvalid || m_tdata[3:0] < 4'(SLOTS))
	`PTT_ASSERT(a_done_from, state_q != ST_DONE || $past(state_q) != ST_IDLE)
	`PTT_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
endmodule
`default_nettype wire

@@ sv/ptt_cell.sv @@
// One timer slot cell; shifts its slot to the neighbor on a scan step.
// Depends on ptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptt_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               shift,
	input  wire ptt_pkg::slot_t     shin,
	input  wire ptt_pkg::cell_cmd_t cmd,
	input  wire logic               here,
	output ptt_pkg::slot_t          slot,
	output ptt_pkg::slot_t          fwd
);
	import ptt_pkg::*;
	slot_t slot_q;
	slot_t upd;
	logic [15:0] rep;
	assign slot = slot_q;
	assign fwd = upd;
	// Apply the command locally; the updated slot is what the neighbor takes.
	always_comb begin
		upd = slot_q;
		rep = slot_q.repeats;
		if (here && cmd.wr) upd = cmd.data;
		if (here && cmd.clr) upd.repeats = '0;
		if (here && cmd.dec) upd.remaining = slot_q.remaining - 16'd1;
		if (here && cmd.fire) begin
			if (!rep[15] && rep != 16'd0) rep = rep - 16'd1;
			upd.repeats = rep;
			if (rep != 16'd0) upd.remaining = slot_q.reload;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slot_q <= '0;
		else slot_q <= shift ? shin : upd;
	end
endmodule
`default_nettype wire
